>>> rtl/max_pool_window_argmax_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the max pooling block
// Short forms for clocked implication checks with the block's reset.
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_WINDOW_ARGMAX_MACROS_SVH
`define MAX_POOL_WINDOW_ARGMAX_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define MPW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define MPW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/mpw_pkg.sv
// ----------------------------------------------------------------------------
// Max pooling package
// Sizes, register codes, reciprocal table and float compare shared by the
// max pooling modules.
// ----------------------------------------------------------------------------
package mpw_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_KERNEL = 8;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int SLOT_W = $clog2(MAX_KERNEL);
    localparam int ADDR_W = SLOT_W + COL_W;
    localparam int DEPTH  = MAX_KERNEL * MAX_WIDTH;

    localparam int SIZE_W     = 11;
    localparam int KERN_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 20;

    localparam logic [VALUE_W-1:0] NEG_INF = 32'hFF80_0000;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_H     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_W     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS  = 3'd7;

    // Quotient x / d for x below 2^10 is (x * RECIP[d]) >> RECIP_SHIFT.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 17;
    localparam int PROD_W      = RECIP_W + ROW_W;
    typedef logic [RECIP_W-1:0] recip_t;
    localparam recip_t RECIP [16] = '{
        17'd65536, 17'd65536, 17'd32768, 17'd21846,
        17'd16384, 17'd13108, 17'd10923, 17'd9363,
        17'd8192,  17'd7282,  17'd6554,  17'd5958,
        17'd5462,  17'd5042,  17'd4682,  17'd4370
    };

    // One window sample headed for the compare unit.
    typedef struct packed {
        logic               start;
        logic [ROW_W-1:0]   origin_row;
        logic [COL_W-1:0]   origin_col;
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
    } scan_in_t;

    // Ordered greater-than on single-precision bits; NaN never compares true.
    function automatic logic fp_greater(input logic [VALUE_W-1:0] a,
                                        input logic [VALUE_W-1:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        logic res;
        a_nan     = (&a[30:23]) && (|a[22:0]);
        b_nan     = (&b[30:23]) && (|b[22:0]);
        both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        if (a_nan || b_nan || both_zero)
        begin
            res = 1'b0;
        end
        else if (a[31] != b[31])
        begin
            res = !a[31];
        end
        else if (!a[31])
        begin
            res = a[30:0] > b[30:0];
        end
        else
        begin
            res = a[30:0] < b[30:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/mpw_ifs.sv
// ----------------------------------------------------------------------------
// Max pooling channels
// Valid/ready channels for input pixels and pooled results.
// ----------------------------------------------------------------------------
interface mpw_pixel_if;
    logic                             valid;
    logic                             ready;
    logic [mpw_pkg::VALUE_W-1:0]      pixel_value;
    logic                             last_in_batch;

    modport source (output valid, output pixel_value, output last_in_batch, input ready);
    modport sink   (input valid, input pixel_value, input last_in_batch, output ready);
endinterface

interface mpw_result_if;
    logic                             valid;
    logic                             ready;
    logic [mpw_pkg::VALUE_W-1:0]      max_value;
    logic [mpw_pkg::INDEX_W-1:0]      argmax_index;
    logic                             batch_done;

    modport source (output valid, output max_value, output argmax_index,
                    output batch_done, input ready);
    modport sink   (input valid, input max_value, input argmax_index,
                    input batch_done, output ready);
endinterface

>>> rtl/mpw_line_store.sv
// ----------------------------------------------------------------------------
// Max pooling line store
// Single-port-write, single-port-read row memory with registered read data.
// ----------------------------------------------------------------------------
module mpw_line_store (
    input  logic                          clk,
    input  logic                          we,
    input  logic [mpw_pkg::ADDR_W-1:0]    waddr,
    input  logic [mpw_pkg::VALUE_W-1:0]   wdata,
    input  logic [mpw_pkg::ADDR_W-1:0]    raddr,
    output logic [mpw_pkg::VALUE_W-1:0]   rdata
);
    import mpw_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/mpw_scan.sv
// ----------------------------------------------------------------------------
// Max pooling compare unit
// Keeps the running maximum and its position over one window scan.
// ----------------------------------------------------------------------------
module mpw_scan (
    input  logic                          clk,
    input  mpw_pkg::scan_in_t             sin,
    output logic [mpw_pkg::VALUE_W-1:0]   best_value,
    output logic [mpw_pkg::ROW_W-1:0]     best_row,
    output logic [mpw_pkg::COL_W-1:0]     best_col
);
    import mpw_pkg::*;

    logic [VALUE_W-1:0] best_value_reg;
    logic [ROW_W-1:0]   best_row_reg;
    logic [COL_W-1:0]   best_col_reg;

    // A new window starts at minus infinity on its origin; a strictly
    // greater sample replaces the best, so ties keep the earlier sample.
    always_ff @(posedge clk)
    begin
        if (sin.start)
        begin
            best_value_reg <= NEG_INF;
            best_row_reg   <= sin.origin_row;
            best_col_reg   <= sin.origin_col;
        end
        else if (sin.valid && fp_greater(sin.value, best_value_reg))
        begin
            best_value_reg <= sin.value;
            best_row_reg   <= sin.row;
            best_col_reg   <= sin.col;
        end
    end

    assign best_value = best_value_reg;
    assign best_row   = best_row_reg;
    assign best_col   = best_col_reg;
endmodule

>>> rtl/max_pool_window_argmax.sv
// ----------------------------------------------------------------------------
// Max pooling with argmax
// Streaming 2-D max pooling over single-precision planes with a line store.
// ----------------------------------------------------------------------------
// One pixel transaction is taken at a time. A pixel that completes no window
// passes through accept, a reciprocal-multiply step for the row slot and
// stride tests, then the line store write. A pixel that closes a window adds
// kernel_height*kernel_width line store reads, one read per cycle through the
// single read port, then a drain of the compare and an output step that forms
// the index. The result sits in an output register, so a stalled result
// blocks only the next window, not the pixels in between.
module max_pool_window_argmax (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mpw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mpw_pkg::CFG_DATA_W-1:0]    cfg_data,
    mpw_pixel_if.sink                         pixel,
    mpw_result_if.source                      result
);
    import mpw_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // Configuration registers.
    logic [SIZE_W-1:0] plane_h_reg, plane_w_reg, out_h_reg, out_w_reg;
    logic [KERN_W-1:0] kern_h_reg, kern_w_reg, stride_r_reg, stride_c_reg;

    logic [2:0]         state_reg, state_next;
    logic [ROW_W-1:0]   row_pos_reg;
    logic [COL_W-1:0]   col_pos_reg;
    logic [VALUE_W-1:0] pix_reg;
    logic               last_reg;
    logic [ROW_W-1:0]   cur_row_reg;
    logic [COL_W-1:0]   cur_col_reg;
    logic [ROW_W-1:0]   q_slot_reg, q_r0_reg;
    logic [COL_W-1:0]   q_c0_reg;
    logic               win_ok_reg;
    logic [ROW_W-1:0]   r0_reg;
    logic [COL_W-1:0]   c0_reg;
    logic [SLOT_W-1:0]  scan_slot_reg;
    logic [SLOT_W-1:0]  dr_reg, dc_reg;
    logic               tag_valid_reg;
    logic [ROW_W-1:0]   tag_row_reg;
    logic [COL_W-1:0]   tag_col_reg;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_done_reg;

    logic [SIZE_W-1:0]  h_eff, w_eff;
    logic [KERN_W-1:0]  kh_eff, kw_eff, sh_eff, sw_eff;
    logic               in_fire;
    logic [SIZE_W-1:0]  row_p1, col_p1;
    logic               win_row, win_col;
    logic [ROW_W-1:0]   r0_calc;
    logic [COL_W-1:0]   c0_calc;
    logic [PROD_W-1:0]  prod_slot, prod_r0, prod_c0;
    logic [ROW_W+KERN_W-1:0] back_slot, back_r0, back_c0;
    logic [SLOT_W-1:0]  slot;
    logic [KERN_W-1:0]  slot_p1;
    logic               emit;
    logic               last_read;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [COL_W-1:0]   scan_col;
    logic [VALUE_W-1:0] rdata;
    scan_in_t           sin;
    logic [VALUE_W-1:0] best_value;
    logic [ROW_W-1:0]   best_row;
    logic [COL_W-1:0]   best_col;
    logic [ROW_W+SIZE_W-1:0] flat_index;
    logic               out_load;

    // Effective sizes: zero acts as one, oversized values saturate.
    always_comb
    begin
        h_eff  = (plane_h_reg == '0) ? SIZE_W'(1) :
                 (plane_h_reg > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : plane_h_reg;
        w_eff  = (plane_w_reg == '0) ? SIZE_W'(1) :
                 (plane_w_reg > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : plane_w_reg;
        kh_eff = (kern_h_reg == '0) ? KERN_W'(1) :
                 (kern_h_reg > KERN_W'(MAX_KERNEL)) ? KERN_W'(MAX_KERNEL) : kern_h_reg;
        kw_eff = (kern_w_reg == '0) ? KERN_W'(1) :
                 (kern_w_reg > KERN_W'(MAX_KERNEL)) ? KERN_W'(MAX_KERNEL) : kern_w_reg;
        sh_eff = (stride_r_reg == '0) ? KERN_W'(1) : stride_r_reg;
        sw_eff = (stride_c_reg == '0) ? KERN_W'(1) : stride_c_reg;
    end

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_h_reg  <= SIZE_W'(1);
            plane_w_reg  <= SIZE_W'(1);
            out_h_reg    <= SIZE_W'(1);
            out_w_reg    <= SIZE_W'(1);
            kern_h_reg   <= KERN_W'(1);
            kern_w_reg   <= KERN_W'(1);
            stride_r_reg <= KERN_W'(1);
            stride_c_reg <= KERN_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PLANE_HEIGHT: plane_h_reg  <= cfg_data;
                REG_PLANE_WIDTH:  plane_w_reg  <= cfg_data;
                REG_OUT_HEIGHT:   out_h_reg    <= cfg_data;
                REG_OUT_WIDTH:    out_w_reg    <= cfg_data;
                REG_KERNEL_H:     kern_h_reg   <= cfg_data[KERN_W-1:0];
                REG_KERNEL_W:     kern_w_reg   <= cfg_data[KERN_W-1:0];
                REG_STRIDE_ROWS:  stride_r_reg <= cfg_data[KERN_W-1:0];
                REG_STRIDE_COLS:  stride_c_reg <= cfg_data[KERN_W-1:0];
                default:          ;
            endcase
        end
    end

    assign in_fire     = pixel.valid && pixel.ready;
    assign pixel.ready = (state_reg == S_IDLE);

    // Window geometry of the latched pixel and the reciprocal products.
    always_comb
    begin
        row_p1    = SIZE_W'(cur_row_reg) + SIZE_W'(1);
        col_p1    = SIZE_W'(cur_col_reg) + SIZE_W'(1);
        win_row   = row_p1 >= SIZE_W'(kh_eff);
        win_col   = col_p1 >= SIZE_W'(kw_eff);
        r0_calc   = ROW_W'(row_p1 - SIZE_W'(kh_eff));
        c0_calc   = COL_W'(col_p1 - SIZE_W'(kw_eff));
        prod_slot = PROD_W'(cur_row_reg) * PROD_W'(RECIP[kh_eff]);
        prod_r0   = PROD_W'(r0_calc) * PROD_W'(RECIP[sh_eff]);
        prod_c0   = PROD_W'(c0_calc) * PROD_W'(RECIP[sw_eff]);
    end

    // Remainders from the registered quotients and the emit decision.
    always_comb
    begin
        back_slot = (ROW_W+KERN_W)'(q_slot_reg) * (ROW_W+KERN_W)'(kh_eff);
        back_r0   = (ROW_W+KERN_W)'(q_r0_reg) * (ROW_W+KERN_W)'(sh_eff);
        back_c0   = (ROW_W+KERN_W)'(q_c0_reg) * (ROW_W+KERN_W)'(sw_eff);
        slot      = SLOT_W'(cur_row_reg - ROW_W'(back_slot));
        slot_p1   = KERN_W'(slot) + KERN_W'(1);
        emit      = win_ok_reg
                    && (back_r0 == (ROW_W+KERN_W)'(r0_reg))
                    && (back_c0 == (ROW_W+KERN_W)'(c0_reg))
                    && (SIZE_W'(q_r0_reg) < out_h_reg)
                    && (SIZE_W'(q_c0_reg) < out_w_reg);
        last_read = (KERN_W'(dr_reg) == kh_eff - KERN_W'(1))
                    && (KERN_W'(dc_reg) == kw_eff - KERN_W'(1));
        scan_col  = c0_reg + COL_W'(dc_reg);
        waddr     = {slot, cur_col_reg};
        raddr     = {scan_slot_reg, scan_col};
    end

    // Sequencer.
    always_comb
    begin
        out_load   = (state_reg == S_OUT) && (!out_valid_reg || result.ready);
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_DIV;
            S_DIV:   state_next = S_WRITE;
            S_WRITE: state_next = emit ? S_SCAN : S_IDLE;
            S_SCAN:  if (last_read) state_next = S_DRAIN;
            S_DRAIN: state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state: sequencer, position and read tag valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            tag_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tag_valid_reg <= (state_reg == S_SCAN);
            if (in_fire)
            begin
                if (pixel.last_in_batch)
                begin
                    row_pos_reg <= '0;
                    col_pos_reg <= '0;
                end
                else if (SIZE_W'(col_pos_reg) + SIZE_W'(1) >= w_eff)
                begin
                    col_pos_reg <= '0;
                    row_pos_reg <= (SIZE_W'(row_pos_reg) + SIZE_W'(1) >= h_eff) ?
                                   '0 : row_pos_reg + ROW_W'(1);
                end
                else
                begin
                    col_pos_reg <= col_pos_reg + COL_W'(1);
                end
            end
        end
    end

    // Working registers of the current pixel and window scan.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pix_reg     <= pixel.pixel_value;
            last_reg    <= pixel.last_in_batch;
            cur_row_reg <= row_pos_reg;
            cur_col_reg <= col_pos_reg;
        end
        if (state_reg == S_DIV)
        begin
            q_slot_reg <= prod_slot[RECIP_SHIFT+ROW_W-1:RECIP_SHIFT];
            q_r0_reg   <= prod_r0[RECIP_SHIFT+ROW_W-1:RECIP_SHIFT];
            q_c0_reg   <= prod_c0[RECIP_SHIFT+COL_W-1:RECIP_SHIFT];
            win_ok_reg <= win_row && win_col;
            r0_reg     <= r0_calc;
            c0_reg     <= c0_calc;
        end
        if (state_reg == S_WRITE)
        begin
            scan_slot_reg <= (slot_p1 == kh_eff) ? '0 : SLOT_W'(slot_p1);
            dr_reg        <= '0;
            dc_reg        <= '0;
        end
        else if (state_reg == S_SCAN)
        begin
            if (KERN_W'(dc_reg) == kw_eff - KERN_W'(1))
            begin
                dc_reg        <= '0;
                dr_reg        <= dr_reg + SLOT_W'(1);
                scan_slot_reg <= (KERN_W'(scan_slot_reg) + KERN_W'(1) == kh_eff) ?
                                 '0 : scan_slot_reg + SLOT_W'(1);
            end
            else
            begin
                dc_reg <= dc_reg + SLOT_W'(1);
            end
        end
        tag_row_reg <= r0_reg + ROW_W'(dr_reg);
        tag_col_reg <= scan_col;
    end

    mpw_line_store u_store (
        .clk   (clk),
        .we    (state_reg == S_WRITE),
        .waddr (waddr),
        .wdata (pix_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Samples to the compare unit.
    always_comb
    begin
        sin.start      = (state_reg == S_WRITE) && emit;
        sin.origin_row = r0_reg;
        sin.origin_col = c0_reg;
        sin.valid      = tag_valid_reg;
        sin.value      = rdata;
        sin.row        = tag_row_reg;
        sin.col        = tag_col_reg;
    end

    mpw_scan u_scan (
        .clk        (clk),
        .sin        (sin),
        .best_value (best_value),
        .best_row   (best_row),
        .best_col   (best_col)
    );

    assign flat_index = (ROW_W+SIZE_W)'(best_row) * (ROW_W+SIZE_W)'(w_eff)
                        + (ROW_W+SIZE_W)'(best_col);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= best_value;
            out_index_reg <= flat_index[INDEX_W-1:0];
            out_done_reg  <= last_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.max_value    = out_value_reg;
    assign result.argmax_index = out_index_reg;
    assign result.batch_done   = out_done_reg;
endmodule

>>> rtl/mpw_checker.sv
// ----------------------------------------------------------------------------
// Max pooling port checker
// Watches the top level's channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "max_pool_window_argmax_macros.svh"

module mpw_port_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    // A result waits until the sink takes it.
    `MPW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // The block works on one pixel at a time.
    `MPW_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "pixel taken while busy")

    // A window result needs the store write and scan, so it never rises in the cycle after a pixel is taken.
    `MPW_ASSERT_NOW(a_no_early_result, $rose(out_valid), !$past(in_valid && in_ready), "result too early")
endmodule

bind max_pool_window_argmax mpw_port_checker u_mpw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (result.valid),
    .out_ready (result.ready)
);

>>> tb/mpw_checker.sv
// ----------------------------------------------------------------------------
// Max pooling result checker
// Mirrors the configuration writes and every accepted pixel, predicts the
// pooled window maximum and its argmax, and compares each result transaction
// with the oldest prediction.
// ----------------------------------------------------------------------------
module mpw_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mpw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpw_pkg::CFG_DATA_W-1:0] cfg_data,
    mpw_pixel_if                           pixel,
    mpw_result_if                          result,
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mpw_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] max_value;
        logic [INDEX_W-1:0] argmax_index;
        logic               batch_done;
    } pooled_t;

    // Mirrored registers and position.
    logic [SIZE_W-1:0] m_plane_h, m_plane_w, m_out_h, m_out_w;
    logic [KERN_W-1:0] m_kern_h, m_kern_w, m_stride_r, m_stride_c;
    logic [31:0]       line_mem [DEPTH];
    int unsigned       cur_row, cur_col;
    pooled_t           pooled_q [$];

    // NaN check on single-precision bits.
    function automatic logic is_nan(input logic [31:0] b);
        return (&b[30:23]) && (|b[22:0]);
    endfunction

    // Monotonic key: larger key means larger float; both zeros share a key.
    function automatic logic [31:0] sort_key(input logic [31:0] b);
        logic [31:0] k;
        if (b[30:0] == 31'd0)
            k = 32'h8000_0000;
        else if (b[31])
            k = ~b;
        else
            k = b | 32'h8000_0000;
        return k;
    endfunction

    function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Store one pixel and predict the window it closes, if any.
    task automatic pool_pixel(input logic [31:0] pix, input logic last);
        int unsigned hh, ww, kh, kw, sh, sw, r, c, r0, c0, br, bc, rr, cc;
        logic [31:0] best, smp;
        pooled_t     p;
        hh = clamp(m_plane_h, 1, MAX_HEIGHT);
        ww = clamp(m_plane_w, 1, MAX_WIDTH);
        kh = clamp(m_kern_h, 1, MAX_KERNEL);
        kw = clamp(m_kern_w, 1, MAX_KERNEL);
        sh = clamp(m_stride_r, 1, 15);
        sw = clamp(m_stride_c, 1, 15);
        r = cur_row;
        c = cur_col;
        line_mem[(r % kh) * MAX_WIDTH + c] = pix;
        if (r + 1 >= kh && c + 1 >= kw)
        begin
            r0 = r + 1 - kh;
            c0 = c + 1 - kw;
            if (r0 % sh == 0 && c0 % sw == 0 && r0 / sh < m_out_h && c0 / sw < m_out_w)
            begin
                best = NEG_INF;
                br = r0;
                bc = c0;
                for (rr = r0; rr <= r; rr++)
                begin
                    for (cc = c0; cc <= c; cc++)
                    begin
                        smp = line_mem[(rr % kh) * MAX_WIDTH + cc];
                        if (!is_nan(smp) && !is_nan(best) && sort_key(smp) > sort_key(best))
                        begin
                            best = smp;
                            br = rr;
                            bc = cc;
                        end
                    end
                end
                p.max_value = best;
                p.argmax_index = INDEX_W'(br * ww + bc);
                p.batch_done = last;
                pooled_q.push_back(p);
            end
        end
        // Advance the raster position.
        if (last)
        begin
            cur_row = 0;
            cur_col = 0;
        end
        else if (c + 1 >= ww)
        begin
            cur_col = 0;
            cur_row = (r + 1 >= hh) ? 0 : r + 1;
        end
        else
        begin
            cur_col = c + 1;
        end
    endtask

    // Watch configuration, pixel and result transactions.
    always @(posedge clk or negedge rst_n)
    begin
        pooled_t want;
        if (!rst_n)
        begin
            m_plane_h = 1; m_plane_w = 1; m_out_h = 1; m_out_w = 1;
            m_kern_h = 1; m_kern_w = 1; m_stride_r = 1; m_stride_c = 1;
            cur_row = 0;
            cur_col = 0;
            errors = 0;
            pooled_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PLANE_HEIGHT: m_plane_h = cfg_data;
                    REG_PLANE_WIDTH:  m_plane_w = cfg_data;
                    REG_OUT_HEIGHT:   m_out_h = cfg_data;
                    REG_OUT_WIDTH:    m_out_w = cfg_data;
                    REG_KERNEL_H:     m_kern_h = cfg_data[KERN_W-1:0];
                    REG_KERNEL_W:     m_kern_w = cfg_data[KERN_W-1:0];
                    REG_STRIDE_ROWS:  m_stride_r = cfg_data[KERN_W-1:0];
                    REG_STRIDE_COLS:  m_stride_c = cfg_data[KERN_W-1:0];
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (pooled_q.size() == 0)
                begin
                    report("unexpected result", result.max_value, 32'd0);
                end
                else
                begin
                    want = pooled_q.pop_front();
                    if (result.max_value !== want.max_value)
                        report("max_value", result.max_value, want.max_value);
                    if (result.argmax_index !== want.argmax_index)
                        report("argmax_index", 32'(result.argmax_index),
                               32'(want.argmax_index));
                    if (result.batch_done !== want.batch_done)
                        report("batch_done", 32'(result.batch_done), 32'(want.batch_done));
                end
            end
            if (pixel.valid && pixel.ready)
                pool_pixel(pixel.pixel_value, pixel.last_in_batch);
        end
        // Number of predicted results not yet seen.
        pending = pooled_q.size();
    end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Max pooling testbench top
// Drives directed and random pixel planes through several configurations,
// stalls the result side at random and once for a long stretch, and gives
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mpw_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  rx_go = 1'b1;
    logic                  hold_off = 1'b0;
    int                    errors;
    int                    pending;
    int                    pixels_sent = 0;
    int                    cycles = 0;

    mpw_pixel_if  pixel ();
    mpw_result_if result ();

    max_pool_window_argmax uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pixel(pixel), .result(result)
    );

    mpw_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pixel(pixel), .result(result),
        .errors(errors), .pending(pending)
    );

    always #1 clk = ~clk;

    assign result.ready = rx_go && !hold_off;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 1000000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly short idle gaps, now and then a long one.
    function automatic int pick_gap();
        int g;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: g = 0;
            5, 6, 7:       g = $urandom_range(1, 3);
            8:             g = $urandom_range(4, 8);
            default:       g = $urandom_range(20, 40);
        endcase
        return g;
    endfunction

    // Receiver: ready stretches broken by random stalls.
    initial
    begin
        int n;
        forever
        begin
            rx_go = 1'b1;
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 10);
            repeat (n) @(negedge clk);
            n = pick_gap();
            if (n > 0)
            begin
                rx_go = 1'b0;
                repeat (n) @(negedge clk);
            end
        end
    end

    // Long receiver hold-off so the block fills up and stalls its input.
    initial
    begin
        wait (pixels_sent >= 300);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
    end

    // Offer one pixel transaction; returns at the falling edge after acceptance.
    task automatic send_pixel(input logic [31:0] value, input logic last);
        int g;
        g = ($urandom_range(0, 4) == 0) ? pick_gap() : 0;
        if (g > 0)
        begin
            pixel.valid = 1'b0;
            repeat (g) @(negedge clk);
        end
        pixel.valid = 1'b1;
        pixel.pixel_value = value;
        pixel.last_in_batch = last;
        do
            @(posedge clk);
        while (!pixel.ready);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Write all eight registers once the block has drained.
    task automatic configure(input int ph, input int pw, input int oh, input int ow,
                             input int kh, input int kw, input int sr, input int sc);
        int vals [8];
        vals = '{ph, pw, oh, ow, kh, kw, sr, sc};
        pixel.valid = 1'b0;
        wait (pending == 0);
        repeat (100) @(negedge clk);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we = 1'b1;
            cfg_index = CFG_IDX_W'(i);
            cfg_data = CFG_DATA_W'(vals[i]);
            @(negedge clk);
        end
        cfg_we = 1'b0;
    endtask

    // Random pixel: special encodings, a small tie-prone set, or any bits.
    function automatic logic [31:0] random_pixel();
        logic [31:0] specials [10];
        logic [31:0] v;
        specials = '{32'h7FC0_0000, 32'hFFFF_FFFF, 32'hFF80_0000, 32'h7F80_0000,
                     32'h8000_0000, 32'h0000_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
                     32'h3F80_0000, 32'hBF80_0000};
        case ($urandom_range(0, 3))
            0:       v = specials[$urandom_range(0, 9)];
            1:       v = {$urandom_range(0, 1) == 1, 8'd127, 21'd0, 2'($urandom)};
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic int pick_size();
        int s;
        case ($urandom_range(0, 19))
            0:       s = 0;
            1:       s = 2047;
            2:       s = 1024;
            default: s = $urandom_range(1, 12);
        endcase
        return s;
    endfunction

    function automatic int pick_small(input int hi);
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, hi);
    endfunction

    initial
    begin
        logic [31:0] plane [16];
        int ph, pw, n;
        pixel.valid = 1'b0;
        pixel.pixel_value = '0;
        pixel.last_in_batch = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: NaN and minus infinity window, signed zero tie, infinities and extremes.
        configure(4, 4, 2, 2, 2, 2, 2, 2);
        plane = '{32'h7FC0_0000, 32'hFF80_0000, 32'h8000_0000, 32'h0000_0000,
                  32'hFFFF_FFFF, 32'hFF80_0000, 32'h0000_0000, 32'h8000_0000,
                  32'h7F80_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001,
                  32'h7FFF_FFFF, 32'h7F80_0000, 32'h8000_0001, 32'hFF7F_FFFF};
        for (int i = 0; i < 16; i++)
            send_pixel(plane[i], i == 15);

        // Random configurations, each ended by a last pixel mark.
        while (pixels_sent < 1200)
        begin
            ph = pick_size();
            pw = pick_size();
            configure(ph, pw, ($urandom_range(0, 9) == 0) ? 2047 : $urandom_range(0, 6),
                      ($urandom_range(0, 9) == 0) ? 2047 : $urandom_range(0, 6),
                      pick_small(4), pick_small(4), pick_small(3), pick_small(3));
            n = ((ph < 1) ? 1 : (ph > 1024 ? 1024 : ph)) * ((pw < 1) ? 1 : (pw > 1024 ? 1024 : pw));
            n = (n > 150) ? $urandom_range(40, 150) : n * $urandom_range(1, 2);
            for (int i = 0; i < n; i++)
                send_pixel(random_pixel(), (i == n - 1) || ($urandom_range(0, 99) == 0));
        end

        pixel.valid = 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
